/* hw/rtl/vbt_pkg.sv */
package vbt_pkg;

  // Default DRAM refresh stall in master cycles
  localparam int unsigned REFRESH_STALL_DFLT = 40;

  localparam logic [7:0]  CHUNK_CYCLES  = 8'd40;
  localparam logic [10:0] LONG_LINE     = 11'd1364;
  localparam logic [10:0] SHORT_LINE    = 11'd1360;
  localparam logic [10:0] REFRESH_EARLY = 11'd534;
  localparam logic [10:0] REFRESH_LATE  = 11'd538;
  localparam logic [10:0] RESET_CYCLES  = 11'd188;
  localparam logic [10:0] LONG_DOT_A    = 11'd1288;
  localparam logic [10:0] LONG_DOT_B    = 11'd1306;
  localparam logic [8:0]  SPECIAL_LINE  = 9'd240;
  localparam logic [8:0]  LINES_NORMAL  = 9'd262;
  localparam logic [8:0]  LINES_LONG    = 9'd263;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SKIP = 1'b1;

  typedef enum logic [1:0] {
    EV_LINE   = 2'd0,
    EV_FRAME  = 2'd1,
    EV_STATUS = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_STATUS
  } eng_state_e;

  typedef struct packed {
    logic [7:0] advance;
    logic       zero;
  } item_t;

  typedef struct packed {
    event_kind_e kind;
    logic        notify;
    logic [8:0]  line;
    logic [8:0]  dot;
    logic [10:0] cycle;
    logic        field;
    logic        last;
  } result_t;

  // Dots around LONG_DOT_A and LONG_DOT_B run long, except on the short line
  function automatic logic [8:0] dot_count(input logic [10:0] cyc, input logic special);
    logic [10:0] h;
    h = cyc;
    if (!special) begin
      if (cyc > LONG_DOT_A) h = h - 11'd2;
      if (cyc > LONG_DOT_B) h = h - 11'd2;
    end
    return h[10:2];
  endfunction

endpackage

/* hw/rtl/video_beam_timing_generator.sv */
// Video beam timing generator. Each input item advances the master clock;
// the engine walks that advance in chunks of at most CHUNK_CYCLES, one
// chunk per clock unless a line event waits on a full result queue,
// inserting the once-per-line DRAM refresh stall, wrapping lines (LONG_LINE
// long, SHORT_LINE on line 240 of a non-interlaced odd field) and frames (262
// lines, 263 on the even field when interlaced). An item yields at most one
// line or frame event (the first line end it causes) followed by a final
// status item carrying the dot counter, with last set. Once running, the
// engine loads the next item in the same cycle as it pushes the last status;
// from idle it loads an item before it walks it. A two-entry input queue
// decouples acceptance from the engine, and a two-entry result queue lets
// the engine keep going while results wait to be taken. Configuration is
// always ready and should only be written while the block is idle; a
// frame_skip write takes effect at the next frame end.
module video_beam_timing_generator #(
  parameter int unsigned REFRESH_STALL = vbt_pkg::REFRESH_STALL_DFLT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    advance_cycles_i,
  // Result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    event_kind_o,
  output logic                          display_notify_o,
  output logic [8:0]                    line_number_o,
  output logic [8:0]                    dot_number_o,
  output logic [10:0]                   line_cycle_o,
  output logic                          field_o,
  output logic                          last_o,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vbt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import vbt_pkg::*;

  item_t   item;
  logic    item_valid, item_pop;
  logic    res_full, res_push;
  result_t res_in, res_out;

  // Registers are plain flops: take every write at once
  assign cfg_ready_o = 1'b1;

  // Front: accept and classify items, hold them for the engine
  vbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .advance_i  (advance_cycles_i),
    .pop_i      (item_pop),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  // Back: chunked beam advance with refresh, line and frame handling
  vbt_engine #(
    .REFRESH_STALL (REFRESH_STALL)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // Result queue: hold events and status until the consumer takes them
  vbt_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (res_in),
    .full_o      (res_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res_out)
  );

  assign event_kind_o     = res_out.kind;
  assign display_notify_o = res_out.notify;
  assign line_number_o    = res_out.line;
  assign dot_number_o     = res_out.dot;
  assign line_cycle_o     = res_out.cycle;
  assign field_o          = res_out.field;
  assign last_o           = res_out.last;

endmodule

/* hw/rtl/vbt_front.sv */
module vbt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     advance_i,
  input  logic           pop_i,
  output logic           valid_o,
  output vbt_pkg::item_t item_o
);
  import vbt_pkg::*;

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && valid_o;
  assign item_o     = entry_q[rd_ptr_q];

  // Classify on entry: flag items that advance nothing
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{advance: advance_i, zero: (advance_i == 8'd0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/vbt_res_fifo.sv */
module vbt_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vbt_pkg::result_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vbt_pkg::result_t out_o
);
  import vbt_pkg::*;

  result_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = push_i && !full_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/vbt_engine.sv */
module vbt_engine #(
  parameter int unsigned REFRESH_STALL = vbt_pkg::REFRESH_STALL_DFLT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_i,
  input  logic [vbt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          item_valid_i,
  input  vbt_pkg::item_t                item_i,
  output logic                          item_pop_o,
  input  logic                          res_full_i,
  output logic                          res_push_o,
  output vbt_pkg::result_t              res_o
);
  import vbt_pkg::*;

  localparam logic [10:0] STALL = 11'(REFRESH_STALL);

  eng_state_e  state_q, state_d;
  logic [7:0]  rem_q, rem_d;
  logic        evt_sent_q;
  logic [10:0] cyc_q, cyc_d;
  logic [8:0]  line_q, line_d;
  logic        field_q, field_d;
  logic [8:0]  lif_q, lif_d;
  logic        short_q, short_d;
  logic        late_q, late_d;
  logic        ref_done_q, ref_done_d;
  logic [7:0]  skip_cnt_q, skip_cnt_d;
  logic [7:0]  skip_pos_q, skip_pos_d;
  logic        skip_chg_q, skip_chg_d;
  logic        notify_q, notify_d;
  logic        interlace_q;
  logic [7:0]  frame_skip_q;

  logic [7:0]  chunk;
  logic [10:0] cyc_a, cyc_b, point, len;
  logic [8:0]  line_inc;
  logic        special_cur, refresh_hit, line_end, frame_end;
  logic        load, step, push_evt, push_sts, stall_chunk;
  result_t     evt_res, sts_res;

  // Chunk datapath: advance, refresh stall, line wrap
  always_comb begin
    chunk       = (rem_q > CHUNK_CYCLES) ? CHUNK_CYCLES : rem_q;
    special_cur = !interlace_q && field_q && (line_q == SPECIAL_LINE);
    cyc_a       = cyc_q + {3'b000, chunk};
    point       = late_q ? REFRESH_LATE : REFRESH_EARLY;
    refresh_hit = !ref_done_q && (cyc_a >= point);
    cyc_b       = refresh_hit ? cyc_a + STALL : cyc_a;
    len         = short_q ? SHORT_LINE : LONG_LINE;
    line_end    = (cyc_b >= len);
    line_inc    = line_q + 9'd1;
    frame_end   = line_end && (line_inc >= lif_q);

    cyc_d      = cyc_b;
    line_d     = line_q;
    field_d    = field_q;
    lif_d      = lif_q;
    short_d    = short_q;
    late_d     = late_q;
    ref_done_d = ref_done_q;
    skip_cnt_d = skip_cnt_q;
    skip_pos_d = skip_pos_q;
    skip_chg_d = skip_chg_q;
    notify_d   = notify_q;

    if (refresh_hit) begin
      ref_done_d = 1'b1;
      if (!special_cur) late_d = ~late_q;
    end
    if (line_end) begin
      cyc_d  = cyc_b - len;
      line_d = line_inc;
      if (frame_end) begin
        if (skip_chg_q) begin
          skip_chg_d = 1'b0;
          skip_cnt_d = frame_skip_q;
          skip_pos_d = 8'd0;
        end else begin
          skip_pos_d = (skip_pos_q == skip_cnt_q) ? 8'd0 : skip_pos_q + 8'd1;
        end
        notify_d = (skip_pos_d == 8'd0);
        line_d   = 9'd0;
        field_d  = ~field_q;
        lif_d    = (interlace_q && !field_d) ? LINES_LONG : LINES_NORMAL;
      end
      short_d    = !interlace_q && field_d && (line_d == SPECIAL_LINE);
      ref_done_d = 1'b0;
    end

    evt_res = '{kind:   frame_end ? EV_FRAME : EV_LINE,
                notify: notify_d,
                line:   line_d,
                dot:    dot_count(cyc_d, !interlace_q && field_d && (line_d == SPECIAL_LINE)),
                cycle:  cyc_d,
                field:  field_d,
                last:   1'b0};
    sts_res = '{kind:   EV_STATUS,
                notify: notify_q,
                line:   line_q,
                dot:    dot_count(cyc_q, special_cur),
                cycle:  cyc_q,
                field:  field_q,
                last:   1'b1};
  end

  assign stall_chunk = line_end && !evt_sent_q && res_full_i;
  assign rem_d       = load ? item_i.advance : rem_q - chunk;

  // FSM outputs
  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    push_evt = 1'b0;
    push_sts = 1'b0;
    case (state_q)
      ST_IDLE: begin
        load = item_valid_i;
      end
      ST_CHUNK: begin
        step     = !stall_chunk;
        push_evt = line_end && !evt_sent_q && !res_full_i;
      end
      ST_STATUS: begin
        push_sts = !res_full_i;
        load     = !res_full_i && item_valid_i;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = item_i.zero ? ST_STATUS : ST_CHUNK;
      end
      ST_CHUNK: begin
        if (step && (rem_d == 8'd0)) state_d = ST_STATUS;
      end
      ST_STATUS: begin
        if (!res_full_i) begin
          if (item_valid_i) state_d = item_i.zero ? ST_STATUS : ST_CHUNK;
          else              state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign item_pop_o = load;
  assign res_push_o = push_evt || push_sts;
  assign res_o      = push_sts ? sts_res : evt_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rem_q        <= 8'd0;
      evt_sent_q   <= 1'b0;
      cyc_q        <= RESET_CYCLES;
      line_q       <= 9'd0;
      field_q      <= 1'b0;
      lif_q        <= LINES_NORMAL;
      short_q      <= 1'b0;
      late_q       <= 1'b1;
      ref_done_q   <= 1'b0;
      skip_cnt_q   <= 8'd0;
      skip_pos_q   <= 8'd0;
      skip_chg_q   <= 1'b0;
      notify_q     <= 1'b0;
      interlace_q  <= 1'b0;
      frame_skip_q <= 8'd0;
    end else begin
      state_q <= state_d;
      if (load || step) rem_q <= rem_d;
      if (step && line_end) evt_sent_q <= 1'b1;
      else if (push_sts)    evt_sent_q <= 1'b0;
      if (step) begin
        cyc_q      <= cyc_d;
        line_q     <= line_d;
        field_q    <= field_d;
        lif_q      <= lif_d;
        short_q    <= short_d;
        late_q     <= late_d;
        ref_done_q <= ref_done_d;
        skip_cnt_q <= skip_cnt_d;
        skip_pos_q <= skip_pos_d;
        notify_q   <= notify_d;
      end
      if (cfg_wr_i && (cfg_index_i == CFG_FRAME_SKIP)) begin
        frame_skip_q <= cfg_data_i;
        skip_chg_q   <= 1'b1;
      end else if (step) begin
        skip_chg_q <= skip_chg_d;
      end
      if (cfg_wr_i && (cfg_index_i == CFG_INTERLACE)) begin
        interlace_q <= cfg_data_i[0];
      end
    end
  end

endmodule

/* tb/tb_video_beam_timing_generator.sv */
module tb_video_beam_timing_generator;
  import vbt_pkg::*;

  localparam int unsigned BEAM_STALL = 40;

  // Directed row: one advance, with the status result pinned where it is obvious
  typedef struct packed {
    logic [7:0]  adv;
    bit          pinned;
    logic [8:0]  line;
    logic [8:0]  dot;
    logic [10:0] cycle;
  } beam_row_t;

  // Random segment: register settings, length and idling for one stretch of items
  typedef struct packed {
    int unsigned items;
    bit          interlace;
    bit          skip_wr;
    logic [7:0]  skip;
    int unsigned tx_pct;
    int unsigned rx_pct;
  } beam_seg_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           advance_cycles_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           event_kind_o;
  logic                 display_notify_o;
  logic [8:0]           line_number_o;
  logic [8:0]           dot_number_o;
  logic [10:0]          line_cycle_o;
  logic                 field_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;

  video_beam_timing_generator #(
    .REFRESH_STALL(BEAM_STALL)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .advance_cycles_i(advance_cycles_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .display_notify_o(display_notify_o),
    .line_number_o   (line_number_o),
    .dot_number_o    (dot_number_o),
    .line_cycle_o    (line_cycle_o),
    .field_o         (field_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Beam state as the predictor tracks it, plus its copy of the registers
  int unsigned beam_cycle;
  logic [8:0]  beam_line;
  logic        beam_field;
  logic [8:0]  field_line_total;
  logic        short_line_q;
  logic        refresh_late_q;
  logic        refresh_done_q;
  logic [7:0]  skip_count;
  logic [7:0]  skip_pos;
  logic        skip_pending;
  logic        notify_q;
  logic        cfg_interlace;
  logic [7:0]  cfg_frame_skip;

  result_t     beam_expect[$];
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  beam_row_t   dir_rows[0:20];
  beam_seg_t   segments[0:5];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Line 240 of an odd field runs short when interlace is off
  function automatic logic on_short_line();
    return !cfg_interlace && beam_field && beam_line == SPECIAL_LINE;
  endfunction

  // Dot counter: two long dots around LONG_DOT_A and LONG_DOT_B except on the short line
  function automatic logic [8:0] beam_dot();
    int unsigned h;
    h = beam_cycle;
    if (!on_short_line()) begin
      if (beam_cycle > LONG_DOT_A) h = h - 2;
      if (beam_cycle > LONG_DOT_B) h = h - 2;
    end
    return 9'(h >> 2);
  endfunction

  function automatic result_t beam_snapshot(event_kind_e kind);
    result_t r;
    r.kind   = kind;
    r.notify = notify_q;
    r.line   = beam_line;
    r.dot    = beam_dot();
    r.cycle  = 11'(beam_cycle);
    r.field  = beam_field;
    r.last   = (kind == EV_STATUS);
    return r;
  endfunction

  function automatic void beam_reset();
    beam_cycle       = RESET_CYCLES;
    beam_line        = '0;
    beam_field       = 1'b0;
    field_line_total = LINES_NORMAL;
    short_line_q     = 1'b0;
    refresh_late_q   = 1'b1;
    refresh_done_q   = 1'b0;
    skip_count       = '0;
    skip_pos         = '0;
    skip_pending     = 1'b0;
    notify_q         = 1'b0;
    cfg_interlace    = 1'b0;
    cfg_frame_skip   = '0;
  endfunction

  // Walk one item's cycles in chunks and queue the results it should give:
  // the first line or frame end it causes, then the status
  function automatic void beam_advance(logic [7:0] adv);
    int unsigned left;
    int unsigned step;
    int unsigned span;
    bit          frame_end;
    bit          reported;
    left     = adv;
    reported = 0;
    while (left != 0) begin
      step = (left > CHUNK_CYCLES) ? CHUNK_CYCLES : left;
      left = left - step;
      beam_cycle = beam_cycle + step;
      if (!refresh_done_q &&
          beam_cycle >= (refresh_late_q ? REFRESH_LATE : REFRESH_EARLY)) begin
        refresh_done_q = 1'b1;
        if (!on_short_line()) refresh_late_q = !refresh_late_q;
        beam_cycle = beam_cycle + BEAM_STALL;
      end
      span = short_line_q ? SHORT_LINE : LONG_LINE;
      if (beam_cycle >= span) begin
        frame_end  = 0;
        beam_cycle = beam_cycle - span;
        beam_line  = beam_line + 9'd1;
        if (beam_line >= field_line_total) begin
          frame_end = 1;
          // A pending frame_skip write restarts the sequence here
          if (skip_pending) begin
            skip_pending = 1'b0;
            skip_count   = cfg_frame_skip;
            skip_pos     = '0;
          end else begin
            skip_pos = 8'((int'(skip_pos) + 1) % (int'(skip_count) + 1));
          end
          notify_q         = (skip_pos == 8'd0);
          beam_line        = '0;
          beam_field       = !beam_field;
          field_line_total = (cfg_interlace && !beam_field) ? LINES_LONG : LINES_NORMAL;
        end
        short_line_q   = on_short_line();
        refresh_done_q = 1'b0;
        if (!reported) begin
          beam_expect.push_back(beam_snapshot(frame_end ? EV_FRAME : EV_LINE));
          reported = 1;
        end
      end
    end
    beam_expect.push_back(beam_snapshot(EV_STATUS));
  endfunction

  // Mostly long advances so the run gets through a frame end
  function automatic logic [7:0] pick_advance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 90) return 8'($urandom_range(255, 224));
    if (r < 95) return 8'($urandom_range(255, 0));
    if (r < 98) return 8'($urandom_range(40, 1));
    return 8'd0;
  endfunction

  // Offer one item, idling first at random; leave valid high on acceptance
  task automatic offer_advance(input logic [7:0] adv);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    advance_cycles_i <= adv;
    do @(posedge clk_i); while (!in_ready_o);
    beam_advance(adv);
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (beam_expect.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leave cfg_valid_i high; the caller drops it after the last write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_INTERLACE) begin
      cfg_interlace = data[0];
    end else begin
      cfg_frame_skip = data;
      skip_pending   = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: exp kind=%0d notify=%0d line=%0d dot=%0d cycle=%0d field=%0d last=%0d",
               $realtime, what, want.kind, want.notify, want.line, want.dot, want.cycle,
               want.field, want.last);
      $display("%0t %s: got kind=%0d notify=%0d line=%0d dot=%0d cycle=%0d field=%0d last=%0d",
               $realtime, what, seen.kind, seen.notify, seen.line, seen.dot, seen.cycle,
               seen.field, seen.last);
    end
  endtask

  // Receiver: stall at random, one decision per edge
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.kind   = event_kind_e'(event_kind_o);
      seen.notify = display_notify_o;
      seen.line   = line_number_o;
      seen.dot    = dot_number_o;
      seen.cycle  = line_cycle_o;
      seen.field  = field_o;
      seen.last   = last_o;
      if (beam_expect.size() == 0) begin
        report_mismatch("result with nothing expected", seen, seen);
      end else begin
        want = beam_expect.pop_front();
        if (seen !== want) report_mismatch("result mismatch", want, seen);
      end
    end
  end

  // Give up after a generous bound; a correct run ends far sooner
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // Start at the reset position, step up to and across the refresh point,
    // through the two long dots, over the line end and on to the next refresh
    dir_rows = '{
      '{8'd0,   1'b1, 9'd0, 9'd47,  11'd188},
      '{8'd255, 1'b1, 9'd0, 9'd110, 11'd443},
      '{8'd1,   1'b1, 9'd0, 9'd111, 11'd444},
      '{8'd40,  1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd39,  1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd11,  1'b1, 9'd0, 9'd133, 11'd534},
      '{8'd4,   1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd255, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd255, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd201, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd17,  1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd1,   1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd56,  1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd1,   1'b1, 9'd1, 9'd0,   11'd0},
      '{8'd255, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd255, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd24,  1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd128, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd170, 1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd85,  1'b0, 9'd0, 9'd0,   11'd0},
      '{8'd255, 1'b0, 9'd0, 9'd0,   11'd0}
    };
    // The random stretches together run a little past the first frame end;
    // interlace changes between most stretches and a frame_skip write is pending
    // when the frame ends, so the skip sequence restarts there.
    segments = '{
      '{320, 1'b0, 1'b1, 8'd0,   26, 51},
      '{320, 1'b1, 1'b1, 8'd255, 26, 51},
      '{320, 1'b1, 1'b0, 8'd0,   51, 26},
      '{320, 1'b0, 1'b0, 8'd0,   51, 26},
      '{300, 1'b1, 1'b1, 8'd1,   0,  0},
      '{300, 1'b0, 1'b1, 8'd170, 0,  0}
    };

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    advance_cycles_i = '0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_INTERLACE;
    cfg_data_i       = '0;
    mismatch_count   = 0;
    tx_idle_pct      = 26;
    rx_idle_pct      = 51;
    beam_reset();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; overwrite the predicted status where the row pins it
    foreach (dir_rows[i]) begin
      offer_advance(dir_rows[i].adv);
      if (dir_rows[i].pinned) begin
        beam_expect[beam_expect.size() - 1] = '{kind: EV_STATUS, notify: 1'b0,
                                                 line: dir_rows[i].line,
                                                 dot: dir_rows[i].dot,
                                                 cycle: dir_rows[i].cycle,
                                                 field: 1'b0, last: 1'b1};
      end
    end

    // Random segments; registers change only once the block has gone quiet
    foreach (segments[s]) begin
      drain_results();
      write_register(CFG_INTERLACE, {7'd0, segments[s].interlace});
      if (segments[s].skip_wr) write_register(CFG_FRAME_SKIP, segments[s].skip);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
      tx_idle_pct = segments[s].tx_pct;
      rx_idle_pct = segments[s].rx_pct;
      for (int n = 0; n < segments[s].items; n++) offer_advance(pick_advance());
    end

    in_valid_i <= 1'b0;
    while (beam_expect.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/vbt_pkg.sv
hw/rtl/vbt_front.sv
hw/rtl/vbt_res_fifo.sv
hw/rtl/vbt_engine.sv
hw/rtl/video_beam_timing_generator.sv
tb/tb_video_beam_timing_generator.sv
